### design/cs_pkg.sv
// ============================================================================
// cs_pkg
// Shared constants and the quarter-wave cosine table for the cosine/sine block.
// ============================================================================
`default_nettype none

package cs_pkg;

    // pipeline split between angle reduction and interpolation
    localparam int REDUCE_STAGES = 5;
    localparam int INTERP_STAGES = 3;
    localparam int NUM_STAGES    = REDUCE_STAGES + INTERP_STAGES;

    // last table index, 90 degrees
    localparam logic [6:0] COS_LAST = 7'd90;

    // cos(k degrees) scaled by 2^30, k = 0..90
    localparam logic [31:0] COS_Q30 [0:90] = '{
        32'd1073741824, 32'd1073578288, 32'd1073087729, 32'd1072270298, 32'd1071126243,
        32'd1069655912, 32'd1067859754, 32'd1065738315, 32'd1063292242, 32'd1060522280,
        32'd1057429273, 32'd1054014162, 32'd1050277989, 32'd1046221891, 32'd1041847103,
        32'd1037154959, 32'd1032146887, 32'd1026824413, 32'd1021189159, 32'd1015242840,
        32'd1008987269, 32'd1002424350, 32'd995556083,  32'd988384560,  32'd980911966,
        32'd973140576,  32'd965072759,  32'd956710970,  32'd948057759,  32'd939115760,
        32'd929887697,  32'd920376381,  32'd910584710,  32'd900515665,  32'd890172315,
        32'd879557810,  32'd868675383,  32'd857528349,  32'd846120104,  32'd834454122,
        32'd822533958,  32'd810363241,  32'd797945680,  32'd785285058,  32'd772385229,
        32'd759250125,  32'd745883746,  32'd732290163,  32'd718473518,  32'd704438018,
        32'd690187940,  32'd675727625,  32'd661061475,  32'd646193961,  32'd631129609,
        32'd615873009,  32'd600428808,  32'd584801711,  32'd568996477,  32'd553017922,
        32'd536870912,  32'd520560366,  32'd504091252,  32'd487468587,  32'd470697435,
        32'd453782903,  32'd436730145,  32'd419544355,  32'd402230767,  32'd384794656,
        32'd367241333,  32'd349576144,  32'd331804471,  32'd313931728,  32'd295963357,
        32'd277904834,  32'd259761657,  32'd241539355,  32'd223243478,  32'd204879599,
        32'd186453311,  32'd167970228,  32'd149435979,  32'd130856211,  32'd112236583,
        32'd93582766,   32'd74900443,   32'd56195305,   32'd37473049,   32'd18739379,
        32'd0
    };

    // table read, indexes past 90 degrees read as zero
    function automatic logic [31:0] cos_q30(input logic [6:0] k);
        logic [31:0] v;
        if (k > COS_LAST) begin
            v = 32'd0;
        end else begin
            v = COS_Q30[k];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### design/fixed_point_cosine_sine.sv
// Throughput: one word per cycle while the output is not stalled; set by the eight-stage pipeline,
// every stage of which loads whenever it is empty or the stage after it moves.
// Reset: synchronous, active low; clears the valid bits only, datapath
// registers hold whatever they had.
// ============================================================================
// fixed_point_cosine_sine
// Cosine or sine of a fixed-point angle in degrees, by table interpolation.
// ============================================================================
`default_nettype none

module fixed_point_cosine_sine #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_func,
    input  wire logic signed [31:0]       s_angle,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [FRAC_BITS+1:0]   m_value
);

    localparam int RS = cs_pkg::REDUCE_STAGES;
    localparam int IS = cs_pkg::INTERP_STAGES;

    logic [cs_pkg::NUM_STAGES-1:0] stage_en;
    logic [FRAC_BITS+6:0]          fold_d;
    logic                          fold_neg;

    // handshake and valid tracking
    cs_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .stage_en  (stage_en)
    );

    // angle reduction
    cs_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
        .aclk     (aclk),
        .en       (stage_en[RS-1:0]),
        .func     (s_func),
        .angle    (s_angle),
        .fold_d   (fold_d),
        .fold_neg (fold_neg)
    );

    // lookup and interpolation
    cs_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
        .aclk     (aclk),
        .en       (stage_en[RS+IS-1:RS]),
        .fold_d   (fold_d),
        .fold_neg (fold_neg),
        .value    (m_value)
    );

endmodule

`default_nettype wire

### design/cs_pipe_ctrl.sv
// ============================================================================
// cs_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// when the stage after it moves, so bubbles close up under a stall.
// ============================================================================
`default_nettype none

module cs_pipe_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cs_pkg::NUM_STAGES-1:0]      stage_en
);

    localparam int N = cs_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   ready;

    // ready ripples back from the output
    always_comb begin
        ready[N] = out_ready;
        for (int i = N - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i + 1];
        end
    end

    // valid bits follow their words
    always_comb begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < N; i++) begin
            if (ready[i]) begin
                valid_next[i] = valid_reg[i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign stage_en  = ready[N-1:0];
    assign in_ready  = ready[0];
    assign out_valid = valid_reg[N-1];

endmodule

`default_nettype wire

### design/cs_reduce.sv
// ============================================================================
// cs_reduce
// Angle reduction: sine offset and magnitude, modulo 360 degrees by reciprocal
// multiply, and folding into 0..90 degrees with a negate flag.
// ============================================================================
`default_nettype none

module cs_reduce #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic [cs_pkg::REDUCE_STAGES-1:0] en,
    input  wire logic                             func,
    input  wire logic signed [31:0]               angle,
    output logic [FRAC_BITS+6:0]                  fold_d,
    output logic                                  fold_neg
);

    localparam int QW = 33 - FRAC_BITS;      // integer degree bits of the magnitude
    localparam int S  = QW + 9;              // reciprocal scale
    localparam int EW = QW - 8;              // quotient estimate bits
    localparam int DW = FRAC_BITS + 9;       // reduced angle, below 360 degrees
    localparam int FW = FRAC_BITS + 7;       // folded angle, up to 90 degrees

    localparam logic [63:0] RECIP64 = (64'd1 << S) / 64'd360;
    localparam logic [QW:0] RECIP   = RECIP64[QW:0];
    localparam logic [32:0] QUARTER_IN = 33'(64'd90 << FRAC_BITS);
    localparam logic [DW-1:0] FULL    = DW'(64'd360 << FRAC_BITS);
    localparam logic [DW-1:0] HALF    = DW'(64'd180 << FRAC_BITS);
    localparam logic [DW-1:0] QUARTER = DW'(64'd90 << FRAC_BITS);
    localparam logic [QW-1:0] DEG360  = QW'(360);
    localparam logic [9:0]    DEG360R = 10'd360;

    // stage 1: sine offset and absolute value
    logic signed [32:0] deg;
    logic [32:0]        mag_next;
    logic [32:0]        mag_reg;

    always_comb begin
        if (func) begin
            deg = $signed(QUARTER_IN) - $signed({angle[31], angle});
        end else begin
            deg = $signed({angle[31], angle});
        end
        mag_next = deg[32] ? (33'd0 - 33'(deg)) : 33'(deg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mag_reg <= mag_next;
        end
    end

    // stage 2: integer degrees times reciprocal of 360
    logic [QW-1:0]        q2_reg;
    logic [FRAC_BITS-1:0] frac2_reg;
    logic [2*QW:0]        prod_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            q2_reg    <= mag_reg[32:FRAC_BITS];
            frac2_reg <= mag_reg[FRAC_BITS-1:0];
            prod_reg  <= mag_reg[32:FRAC_BITS] * RECIP;
        end
    end

    // stage 3: raw remainder, below twice 360
    logic [EW-1:0]        est;
    logic [QW-1:0]        est_w;
    logic [QW-1:0]        est360;
    logic [QW-1:0]        rem_full;
    logic [9:0]           rem_reg;
    logic [FRAC_BITS-1:0] frac3_reg;

    always_comb begin
        est      = prod_reg[S +: EW];
        est_w    = QW'(est);
        est360   = QW'(est_w * DEG360);
        rem_full = q2_reg - est360;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            rem_reg   <= 10'(rem_full);
            frac3_reg <= frac2_reg;
        end
    end

    // stage 4: remainder correction
    logic [9:0]    rem_fix;
    logic [DW-1:0] d_next;
    logic [DW-1:0] d_reg;

    always_comb begin
        rem_fix = (rem_reg >= DEG360R) ? (rem_reg - DEG360R) : rem_reg;
        d_next  = {rem_fix[8:0], frac3_reg};
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            d_reg <= d_next;
        end
    end

    // stage 5: fold into 0..90 degrees
    logic [DW-1:0] d_half;
    logic [DW-1:0] d_quad;
    logic          neg_next;
    logic [FW-1:0] fold_reg;
    logic          neg_reg;

    always_comb begin
        d_half = (d_reg >= HALF) ? (FULL - d_reg) : d_reg;
        if (d_half >= QUARTER) begin
            d_quad   = HALF - d_half;
            neg_next = 1'b1;
        end else begin
            d_quad   = d_half;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            fold_reg <= d_quad[FW-1:0];
            neg_reg  <= neg_next;
        end
    end

    assign fold_d   = fold_reg;
    assign fold_neg = neg_reg;

endmodule

`default_nettype wire

### design/cs_interp.sv
// ============================================================================
// cs_interp
// Table lookup on the whole degree, linear interpolation on the fraction,
// and the final sign.
// ============================================================================
`default_nettype none

module cs_interp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic [cs_pkg::INTERP_STAGES-1:0] en,
    input  wire logic [FRAC_BITS+6:0]             fold_d,
    input  wire logic                             fold_neg,
    output logic signed [FRAC_BITS+1:0]           value
);

    localparam int TW  = FRAC_BITS + 1;
    localparam int OW  = FRAC_BITS + 2;
    localparam int TSH = 30 - FRAC_BITS;
    localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

    // stage 1: read both neighbors, clamped at 90 degrees
    logic [6:0]  k;
    logic [6:0]  k1;
    logic [31:0] e0;
    logic [31:0] e1;

    logic [TW-1:0]        t0_reg;
    logic [TW-1:0]        t1_reg;
    logic [FRAC_BITS-1:0] f_reg;
    logic                 neg1_reg;

    always_comb begin
        k  = fold_d[FRAC_BITS +: 7];
        k1 = (k == cs_pkg::COS_LAST) ? k : (k + 7'd1);
        e0 = cs_pkg::cos_q30(k) >> TSH;
        e1 = cs_pkg::cos_q30(k1) >> TSH;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t0_reg   <= e0[TW-1:0];
            t1_reg   <= e1[TW-1:0];
            f_reg    <= fold_d[FRAC_BITS-1:0];
            neg1_reg <= fold_neg;
        end
    end

    // stage 2: weighted products
    logic [TW-1:0]   w0;
    logic [2*TW-1:0] p0_reg;
    logic [2*TW-1:0] p1_reg;
    logic            neg2_reg;

    assign w0 = ONE_T - {1'b0, f_reg};

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p0_reg   <= t0_reg * w0;
            p1_reg   <= t1_reg * {1'b0, f_reg};
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: sum, scale back and apply sign
    logic [2*TW-1:0] sum;
    logic [OW-1:0]   mag;
    logic [OW-1:0]   val_next;
    logic [OW-1:0]   val_reg;

    always_comb begin
        sum      = p0_reg + p1_reg;
        mag      = {1'b0, sum[FRAC_BITS +: TW]};
        val_next = neg2_reg ? (OW'(0) - mag) : mag;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            val_reg <= val_next;
        end
    end

    assign value = $signed(val_reg);

endmodule

`default_nettype wire

### design/cs_checker.sv
// ============================================================================
// cs_checker
// Port-level checks on the cosine/sine block, bound to the top level.
// ============================================================================
`default_nettype none

module cs_checker #(
    parameter int FRAC_BITS = 16
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   s_func,
    input wire logic signed [31:0]     s_angle,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic signed [FRAC_BITS+1:0] m_value
);

    localparam logic signed [FRAC_BITS+1:0] ONE_S = (FRAC_BITS+2)'(1) << FRAC_BITS;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("result word changed under stall");

    // results stay within plus and minus one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value <= ONE_S) && (m_value >= -ONE_S))
        else $error("result out of range");

    // an unstalled output never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output drains");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind fixed_point_cosine_sine cs_checker #(.FRAC_BITS(FRAC_BITS)) u_cs_checker (.*);

`default_nettype wire
